// File: design/tdsc_pkg.sv
// shared constants for the temperature compensated tds converter
package tdsc_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int FRAC_BITS    = 16;
  localparam int TEMP_W       = 11;
  localparam int PPM_W        = 14;

  // 3.3 V full scale times 800 for the compensation factor (t + 400) / 800
  localparam int VSCALE   = 2640;
  localparam int TEMP_OFS = 400;

  // divider widths: numerator below 2640 * 2^16, quotient below 2^19
  localparam int NUM_W = 28;
  localparam int DEN_W = 12;
  localparam int VQ_W  = 19;

  localparam int V2_W = 22;
  localparam int V3_W = 25;

  // cubic coefficients in 1/100
  localparam int C3 = 13342;
  localparam int C2 = 25586;
  localparam int C1 = 85739;

  localparam int P3_W = 38;
  localparam int P2_W = 37;
  localparam int P1_W = 36;
  localparam int S_W  = 40;

  // floor(s / (25 * 2^15)) as a shift then a reciprocal multiply by 1/25
  localparam int OUT_SH   = 15;
  localparam int X_W      = 24;
  localparam int RECIP_W  = 25;
  localparam int RECIP_M  = 21474837;
  localparam int RECIP_SH = 29;
  localparam int Q_W      = 20;

  localparam logic [PPM_W-1:0] CEIL_RST = PPM_W'(16000);

endpackage

// File: design/tdsc_if.sv
// handshake channels for the tds converter
interface tdsc_in_if import tdsc_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_raw;
  logic [TEMP_W-1:0]   water_temp;

  modport source (output valid, adc_raw, water_temp, input ready);
  modport sink   (input valid, adc_raw, water_temp, output ready);
endinterface

interface tdsc_out_if import tdsc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PPM_W-1:0] tds_ppm;
  logic             clamped;

  modport source (output valid, tds_ppm, clamped, input ready);
  modport sink   (input valid, tds_ppm, clamped, output ready);
endinterface

interface tdsc_cfg_if import tdsc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PPM_W-1:0] ppm_ceiling;

  modport source (output valid, ppm_ceiling, input ready);
  modport sink   (input valid, ppm_ceiling, output ready);
endinterface

// File: design/tdsc_div.sv
// pipelined restoring divider, one quotient bit per stage
module tdsc_div import tdsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VQ_W-1:0]  quo
);

  logic             v_r   [VQ_W];
  logic [DEN_W-1:0] rem_r [VQ_W];
  logic [VQ_W-1:0]  wrk_r [VQ_W];
  logic [DEN_W-1:0] den_r [VQ_W];
  logic             en    [VQ_W];

  for (genvar k = 0; k < VQ_W; k++) begin : g_stage
    logic             v_src;
    logic [DEN_W-1:0] rem_src;
    logic [VQ_W-1:0]  wrk_src;
    logic [DEN_W-1:0] den_src;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    logic [VQ_W-1:0]  wrk_nxt;

    if (k == 0) begin : g_first
      assign v_src   = in_valid;
      assign rem_src = {{(DEN_W-(NUM_W-VQ_W)){1'b0}}, num[NUM_W-1:VQ_W]};
      assign wrk_src = num[VQ_W-1:0];
      assign den_src = den;
    end else begin : g_next
      assign v_src   = v_r[k-1];
      assign rem_src = rem_r[k-1];
      assign wrk_src = wrk_r[k-1];
      assign den_src = den_r[k-1];
    end

    if (k == VQ_W-1) begin : g_last_en
      assign en[k] = !v_r[k] || out_ready;
    end else begin : g_mid_en
      assign en[k] = !v_r[k] || en[k+1];
    end

    assign trial   = {rem_src, wrk_src[VQ_W-1]};
    assign ge      = trial >= {1'b0, den_src};
    assign rem_nxt = ge ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];
    assign wrk_nxt = {wrk_src[VQ_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt;
        wrk_r[k] <= wrk_nxt;
        den_r[k] <= den_src;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[VQ_W-1];
  assign quo       = wrk_r[VQ_W-1];

endmodule

// File: design/tds_from_adc_temp_compensated.sv
// tds converter top level: adc code and water temperature to compensated tds
// One item enters per clock while the pipeline has room and passes 19 stages
// of a restoring divider that forms one bit of the compensated voltage each,
// then six stages for the square, the cube, the coefficient products, the sum,
// the scaling to 1/16 ppm and the clamp in the output register. Stalls at the
// output fill empty stages first, so items keep entering until the pipeline
// is full. The ceiling register may be written at any time the block is idle.
module tds_from_adc_temp_compensated import tdsc_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tdsc_in_if.sink     in_ch,
  tdsc_out_if.source  out_ch,
  tdsc_cfg_if.sink    cfg_ch
);

  localparam int NST = 5;

  logic [PPM_W-1:0] ceil_r;

  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_valid;
  logic [VQ_W-1:0]  div_quo;

  logic             v_r [NST];
  logic             en  [NST+1];

  logic [VQ_W-1:0]  s1_vq_r;
  logic [V2_W-1:0]  s1_v2_r;
  logic [VQ_W-1:0]  s2_vq_r;
  logic [V2_W-1:0]  s2_v2_r;
  logic [V3_W-1:0]  s2_v3_r;
  logic [P3_W-1:0]  s3_p3_r;
  logic [P2_W-1:0]  s3_p2_r;
  logic [P1_W-1:0]  s3_p1_r;
  logic [S_W-1:0]   s4_sum_r;
  logic             s5_neg_r;
  logic [Q_W-1:0]   s5_q_r;

  logic             out_valid_r;
  logic [PPM_W-1:0] tds_r;
  logic             clamped_r;

  logic [2*VQ_W-1:0]        sq_nxt;
  logic [V2_W+VQ_W-1:0]     cube_nxt;
  logic [S_W-1:0]           sum_nxt;
  logic [X_W-1:0]           x_val;
  logic [X_W+RECIP_W-1:0]   recip_nxt;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= CEIL_RST;
    end else if (cfg_ch.valid) begin
      ceil_r <= cfg_ch.ppm_ceiling;
    end
  end

  // voltage times 800 in Q16, with the adc scale folded in
  assign div_num = NUM_W'((NUM_W'(in_ch.adc_raw) * NUM_W'(VSCALE))
                          << (FRAC_BITS - ADC_BITS));
  assign div_den = DEN_W'(in_ch.water_temp) + DEN_W'(TEMP_OFS);

  tdsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .num       (div_num),
    .den       (div_den),
    .out_valid (div_valid),
    .out_ready (en[0]),
    .quo       (div_quo)
  );

  // stall chain
  assign en[NST] = !out_valid_r || out_ch.ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        v_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (en[0]) begin
        v_r[0] <= div_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
      if (en[NST]) begin
        out_valid_r <= v_r[NST-1];
      end
    end
  end

  // datapath
  assign sq_nxt    = (2*VQ_W)'(div_quo) * (2*VQ_W)'(div_quo);
  assign cube_nxt  = (V2_W+VQ_W)'(s1_v2_r) * (V2_W+VQ_W)'(s1_vq_r);
  assign sum_nxt   = S_W'(s3_p3_r) - S_W'(s3_p2_r) + S_W'(s3_p1_r);
  assign x_val     = s4_sum_r[OUT_SH+X_W-1:OUT_SH];
  assign recip_nxt = (X_W+RECIP_W)'(x_val) * (X_W+RECIP_W)'(RECIP_M);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_vq_r <= div_quo;
      s1_v2_r <= sq_nxt[FRAC_BITS+V2_W-1:FRAC_BITS];
    end
    if (en[1]) begin
      s2_vq_r <= s1_vq_r;
      s2_v2_r <= s1_v2_r;
      s2_v3_r <= cube_nxt[FRAC_BITS+V3_W-1:FRAC_BITS];
    end
    if (en[2]) begin
      s3_p3_r <= P3_W'(s2_v3_r) * P3_W'(C3);
      s3_p2_r <= P2_W'(s2_v2_r) * P2_W'(C2);
      s3_p1_r <= P1_W'(s2_vq_r) * P1_W'(C1);
    end
    if (en[3]) begin
      s4_sum_r <= sum_nxt;
    end
    if (en[4]) begin
      s5_neg_r <= s4_sum_r[S_W-1];
      s5_q_r   <= recip_nxt[RECIP_SH+Q_W-1:RECIP_SH];
    end
    if (en[NST]) begin
      if (s5_neg_r) begin
        tds_r     <= '0;
        clamped_r <= 1'b1;
      end else if (s5_q_r > Q_W'(ceil_r)) begin
        tds_r     <= ceil_r;
        clamped_r <= 1'b1;
      end else begin
        tds_r     <= s5_q_r[PPM_W-1:0];
        clamped_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.tds_ppm = tds_r;
  assign out_ch.clamped = clamped_r;

endmodule

// File: design/tdsc_chk.sv
// port level checks for the tds converter
module tdsc_chk import tdsc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PPM_W-1:0] tds_ppm,
  input logic             clamped,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [PPM_W-1:0] cfg_data
);

  logic [PPM_W-1:0] ceil_r;
  logic [5:0]       cnt_r;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= CEIL_RST;
      cnt_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ceil_r <= cfg_data;
      end
      if (in_acc && !out_acc) begin
        cnt_r <= cnt_r + 6'd1;
      end else if (out_acc && !in_acc) begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tds_ppm) && $stable(clamped))
    else $error("stalled result changed");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 6'd0)
    else $error("result without an item in flight");

  a_unclamped_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !clamped |-> tds_ppm <= ceil_r)
    else $error("unclamped result above ceiling");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clamped |-> tds_ppm == '0 || tds_ppm == ceil_r)
    else $error("clamped result not at a limit");

endmodule

bind tds_from_adc_temp_compensated tdsc_chk u_tdsc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .tds_ppm   (out_ch.tds_ppm),
  .clamped   (out_ch.clamped),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .cfg_data  (cfg_ch.ppm_ceiling)
);

// File: tb/tb_tds_from_adc_temp_compensated.sv
`timescale 1ns / 100ps
// self-checking testbench for the temperature compensated tds converter
module tb_tds_from_adc_temp_compensated;
  import tdsc_pkg::*;

  localparam int ADC_W       = ADC_BITS_DEF;
  localparam int LATENCY     = 25;
  localparam int IDLE_LIMIT  = 4000;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 85;
  localparam int N_DIRECTED  = 21;

  typedef enum logic {STEP_SAMPLE, STEP_CEIL} step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    logic [PPM_W-1:0]   a;
    logic [TEMP_W-1:0]  b;
    logic               typed;
    logic [PPM_W-1:0]   exp_tds;
    logic               exp_clamped;
  } stim_row_t;

  typedef struct packed {
    logic [PPM_W-1:0] tds;
    logic             clamped;
  } tds_result_t;

  typedef struct packed {
    logic        typed;
    tds_result_t value;
  } typed_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tdsc_in_if #(.ADC_BITS(ADC_W)) in_ch ();
  tdsc_out_if                    out_ch ();
  tdsc_cfg_if                    cfg_ch ();

  tds_from_adc_temp_compensated #(.ADC_BITS(ADC_W)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{STEP_SAMPLE, 14'd0,     11'd0,    1'b1, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd0,     11'd2047, 1'b1, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd4095,  11'd0,    1'b1, 14'd16000, 1'b1},
    '{STEP_SAMPLE, 14'd4095,  11'd400,  1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd4095,  11'd1600, 1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd4095,  11'd2047, 1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd1,     11'd0,    1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd1,     11'd2047, 1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd2048,  11'd400,  1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd1365,  11'd400,  1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd2730,  11'd1024, 1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd2730,  11'd1365, 1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd1365,  11'd682,  1'b0, 14'd0,     1'b0},
    '{STEP_CEIL,   14'd16383, 11'd0,    1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd4095,  11'd0,    1'b1, 14'd16383, 1'b1},
    '{STEP_SAMPLE, 14'd2048,  11'd400,  1'b0, 14'd0,     1'b0},
    '{STEP_CEIL,   14'd0,     11'd0,    1'b0, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd0,     11'd1600, 1'b1, 14'd0,     1'b0},
    '{STEP_SAMPLE, 14'd1,     11'd0,    1'b1, 14'd0,     1'b1},
    '{STEP_SAMPLE, 14'd4095,  11'd2047, 1'b1, 14'd0,     1'b1},
    '{STEP_CEIL,   14'd16000, 11'd0,    1'b0, 14'd0,     1'b0}
  };

  tds_result_t      tds_expect_q [$];
  typed_result_t    typed_q [$];
  logic [PPM_W-1:0] ceiling_model = PPM_W'(16000);
  tds_result_t      want;
  typed_result_t    tag;
  int               fail_count = 0;
  bit               calm = 1'b0;

  function automatic tds_result_t predict_tds(input logic [ADC_W-1:0] raw,
                                              input logic [TEMP_W-1:0] temp,
                                              input logic [PPM_W-1:0] ceiling);
    longint unsigned num, den, vq, v2, v3, q;
    longint          s;
    tds_result_t     r;
    num = (64'(raw) * 64'd2640) << 16;
    den = (64'(temp) + 64'd400) << ADC_W;
    vq  = num / den;
    v2  = (vq * vq) >> 16;
    v3  = (v2 * vq) >> 16;
    s   = longint'(64'd13342 * v3) - longint'(64'd25586 * v2) + longint'(64'd85739 * vq);
    r.clamped = 1'b0;
    if (s < 0) begin
      r.tds     = '0;
      r.clamped = 1'b1;
    end else begin
      q = ($unsigned(s) * 64'd2) / (64'd25 * 64'd65536);
      if (q > 64'(ceiling)) begin
        r.tds     = ceiling;
        r.clamped = 1'b1;
      end else begin
        r.tds = PPM_W'(q);
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 50) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 60));
  endfunction

  task automatic push_sample(input logic [ADC_W-1:0] raw, input logic [TEMP_W-1:0] temp,
                             input logic typed, input logic [PPM_W-1:0] e_tds,
                             input logic e_clamped);
    int            gap;
    typed_result_t t;
    gap = pick_gap();
    t.typed = typed;
    t.value.tds = e_tds;
    t.value.clamped = e_clamped;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    typed_q.push_back(t);
    in_ch.valid      <= 1'b1;
    in_ch.adc_raw    <= raw;
    in_ch.water_temp <= temp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_ceiling(input logic [PPM_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.ppm_ceiling <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tds_expect_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic push_random();
    int                 r;
    logic [ADC_W-1:0]   raw;
    logic [TEMP_W-1:0]  temp;
    r = int'($urandom_range(0, 99));
    if (r < 55) begin
      raw  = ADC_W'($urandom_range(0, 2600));
      temp = TEMP_W'($urandom_range(200, 1600));
    end else if (r < 85) begin
      raw  = ADC_W'($urandom);
      temp = TEMP_W'($urandom_range(0, 1600));
    end else begin
      raw  = ADC_W'($urandom);
      temp = TEMP_W'($urandom_range(1601, 2047));
    end
    push_sample(raw, temp, 1'b0, '0, 1'b0);
  endtask

  // scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) ceiling_model = cfg_ch.ppm_ceiling;
      if (out_ch.valid && out_ch.ready) begin
        if (tds_expect_q.size() == 0) begin
          $display("%0t: unexpected result, tds_ppm %0d clamped %0d",
                   $time, out_ch.tds_ppm, out_ch.clamped);
          fail_count++;
        end else begin
          want = tds_expect_q.pop_front();
          if (out_ch.tds_ppm !== want.tds) begin
            $display("%0t: tds_ppm mismatch, expected %0d, got %0d",
                     $time, want.tds, out_ch.tds_ppm);
            fail_count++;
          end
          if (out_ch.clamped !== want.clamped) begin
            $display("%0t: clamped mismatch, expected %0d, got %0d",
                     $time, want.clamped, out_ch.clamped);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        tag  = typed_q.pop_front();
        want = predict_tds(in_ch.adc_raw, in_ch.water_temp, ceiling_model);
        if (tag.typed) want = tag.value;
        tds_expect_q.push_back(want);
      end
    end
  end

  initial begin
    int run;
    int stall;
    forever begin
      run = int'($urandom_range(1, 16));
      repeat (run) @(negedge clk) out_ch.ready <= 1'b1;
      stall = pick_gap();
      repeat (stall) @(negedge clk) out_ch.ready <= 1'b0;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int                phase;
    logic [PPM_W-1:0]  ceiling;
    logic [ADC_W-1:0]  raw;
    logic [TEMP_W-1:0] temp;
    tds_result_t       probe;
    bit                exact;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.adc_raw      = '0;
    in_ch.water_temp   = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.ppm_ceiling = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == STEP_CEIL) begin
        settle();
        write_ceiling(directed_rows[i].a);
      end else begin
        push_sample(directed_rows[i].a[ADC_W-1:0], directed_rows[i].b, directed_rows[i].typed,
                    directed_rows[i].exp_tds, directed_rows[i].exp_clamped);
      end
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      settle();
      calm  = (phase % 4 == 1);
      exact = 1'b0;
      raw   = '0;
      temp  = '0;
      case (phase)
        0: ceiling = PPM_W'(16383);
        1: ceiling = '0;
        2: ceiling = PPM_W'(16000);
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            ceiling = PPM_W'($urandom_range(0, 16383));
          end else begin
            // ceiling equal to one result, so that result sits on the limit, unclamped if below 16384
            exact   = 1'b1;
            raw     = ADC_W'($urandom_range(1, 2600));
            temp    = TEMP_W'($urandom_range(0, 1600));
            probe   = predict_tds(raw, temp, '1);
            ceiling = probe.tds;
          end
        end
      endcase
      write_ceiling(ceiling);
      if (exact) push_sample(raw, temp, 1'b0, '0, 1'b0);
      repeat (PHASE_ITEMS) push_random();
    end

    settle();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
design/tdsc_pkg.sv
design/tdsc_if.sv
design/tdsc_div.sv
design/tds_from_adc_temp_compensated.sv
design/tdsc_chk.sv
tb/tb_tds_from_adc_temp_compensated.sv
